>>> src/header_token_lexer_core_defines.svh
// Assertion macros shared by the lexer RTL.
// Needs a clk and an arst_n in the scope of each use.
`ifndef HEADER_TOKEN_LEXER_CORE_DEFINES_SVH
`define HEADER_TOKEN_LEXER_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define HTL_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define HTL_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> src/htl_pkg.sv
// Types, codes and keyword tables for the header token lexer.
// No dependencies; used by htl_lex_step and header_token_lexer_core.
`default_nettype none

package htl_pkg;

	localparam int TLEN_W = 6;
	localparam int KW_N   = 11;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} htl_in_t;

	typedef struct packed {
		logic       token_valid;
		logic [4:0] token_kind;
		logic [7:0] text_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_done;
		logic [2:0] error_code;
	} htl_out_t;

	typedef enum logic [4:0] {
		LX_SPACE, LX_IGNORE, LX_WORD, LX_DIGIT, LX_LPAREN, LX_RPAREN, LX_LBRACE,
		LX_RBRACE, LX_SEMI, LX_ASSIGN, LX_QUOTE, LX_LANGLE, LX_RANGLE, LX_STAR,
		LX_AMP, LX_COLON, LX_DCOLON, LX_SLASH, LX_LINECOM, LX_BLOCKCOM, LX_BLOCKSTAR
	} lx_state_t;

	localparam logic [4:0] KIND_NAME   = 5'd0;
	localparam logic [4:0] KIND_NUMBER = 5'd1;
	localparam logic [4:0] KIND_STRING = 5'd2;
	localparam logic [4:0] KIND_LPAREN = 5'd3;
	localparam logic [4:0] KIND_RPAREN = 5'd4;
	localparam logic [4:0] KIND_LBRACE = 5'd5;
	localparam logic [4:0] KIND_RBRACE = 5'd6;
	localparam logic [4:0] KIND_SEMI   = 5'd7;
	localparam logic [4:0] KIND_ASSIGN = 5'd8;
	localparam logic [4:0] KIND_LANGLE = 5'd9;
	localparam logic [4:0] KIND_RANGLE = 5'd10;
	localparam logic [4:0] KIND_STAR   = 5'd11;
	localparam logic [4:0] KIND_AMP    = 5'd12;
	localparam logic [4:0] KIND_COLON  = 5'd13;
	localparam logic [4:0] KIND_DCOLON = 5'd14;
	localparam logic [4:0] KIND_SLASH  = 5'd15;
	localparam logic [4:0] KIND_KW0    = 5'd16;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_PAREN   = 3'd1;
	localparam logic [2:0] ERR_BRACE   = 3'd2;
	localparam logic [2:0] ERR_UNCLOSED = 3'd3;
	localparam logic [2:0] ERR_TOKEN   = 3'd4;
	localparam logic [2:0] ERR_NEST    = 3'd5;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	// keyword text, right aligned in 9 bytes
	localparam logic [71:0] KW_TEXT [KW_N] = '{
		72'("class"), 72'("struct"), 72'("static"), 72'("const"), 72'("inline"),
		72'("public"), 72'("protected"), 72'("private"), 72'("CLASS"),
		72'("PROPERTY"), 72'("FUNCTION")
	};
	localparam logic [3:0] KW_LEN [KW_N] = '{
		4'd5, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd9, 4'd7, 4'd5, 4'd8, 4'd8
	};

	typedef struct packed {
		logic              emit;
		logic [4:0]        kind;
		lx_state_t         nstate;
		logic [TLEN_W-1:0] nlen;
		logic              nesc;
		logic              wr;
		logic [TLEN_W-1:0] waddr;
		logic              push;
		logic              push_bit;
		logic              pop;
		logic [2:0]        err;
		logic [KW_N-1:0]   match;
	} lex_res_t;

	function automatic logic [7:0] kw_char(input int k, input logic [TLEN_W-1:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (p < TLEN_W'(KW_LEN[k]))
			r = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(p)) +: 8];
		return r;
	endfunction

	function automatic lx_state_t char_class(input logic [7:0] c);
		lx_state_t r;
		case (c) inside
			["0":"9"]:             r = LX_DIGIT;
			["a":"z"], ["A":"Z"]:  r = LX_WORD;
			CH_SPACE, CH_NL, 8'h09: r = LX_SPACE;
			"=":                   r = LX_ASSIGN;
			"(":                   r = LX_LPAREN;
			")":                   r = LX_RPAREN;
			CH_QUOTE:              r = LX_QUOTE;
			"<":                   r = LX_LANGLE;
			">":                   r = LX_RANGLE;
			"{":                   r = LX_LBRACE;
			"}":                   r = LX_RBRACE;
			";":                   r = LX_SEMI;
			"*":                   r = LX_STAR;
			"&":                   r = LX_AMP;
			":":                   r = LX_COLON;
			"/":                   r = LX_SLASH;
			default:               r = LX_IGNORE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/htl_lex_step.sv
// Next-state logic for one source byte of the lexer: state, buffer write,
// stack push/pop, token emit and error. Depends on htl_pkg.
`default_nettype none

module htl_lex_step (
	input  htl_pkg::lx_state_t             state,
	input  logic [7:0]                     c,
	input  logic                           esc,
	input  logic [htl_pkg::TLEN_W-1:0]     len,
	input  logic [htl_pkg::KW_N-1:0]       match,
	input  logic                           tok_full,
	input  logic                           nest_empty,
	input  logic                           nest_full,
	input  logic                           nest_top,
	output htl_pkg::lex_res_t              res
);
	import htl_pkg::*;

	logic [KW_N-1:0] app_match, start_match;
	logic [4:0]      word_kind;
	logic            st, ap;
	logic            is_dig, is_let;

	assign is_dig = (c >= "0") && (c <= "9");
	assign is_let = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

	// keyword candidates narrowed one byte at a time
	always_comb begin
		word_kind = KIND_NAME;
		for (int k = 0; k < KW_N; k++) begin
			app_match[k]   = match[k] && (len < TLEN_W'(KW_LEN[k])) && (kw_char(k, len) == c);
			start_match[k] = (kw_char(k, '0) == c);
			if (match[k] && (len == TLEN_W'(KW_LEN[k])))
				word_kind = 5'(int'(KIND_KW0) + k);
		end
	end

	always_comb begin
		res        = '0;
		res.nstate = state;
		res.nlen   = len;
		res.nesc   = esc;
		res.match  = match;
		st = 1'b0;
		ap = 1'b0;
		case (state)
			LX_WORD: begin
				if (is_let || is_dig) ap = 1'b1;
				else begin res.emit = 1'b1; res.kind = word_kind; st = 1'b1; end
			end
			LX_DIGIT: begin
				if (is_dig || c == ".") ap = 1'b1;
				else if (c != "f" && c != "L") begin
					res.emit = 1'b1; res.kind = KIND_NUMBER; st = 1'b1;
				end
			end
			LX_LPAREN, LX_LBRACE: begin
				res.emit = 1'b1;
				res.kind = (state == LX_LPAREN) ? KIND_LPAREN : KIND_LBRACE;
				if (nest_full) res.err = ERR_NEST;
				else begin
					res.push = 1'b1;
					res.push_bit = (state == LX_LBRACE);
					st = 1'b1;
				end
			end
			LX_RPAREN, LX_RBRACE: begin
				res.emit = 1'b1;
				res.kind = (state == LX_RPAREN) ? KIND_RPAREN : KIND_RBRACE;
				if (nest_empty || nest_top != (state == LX_RBRACE))
					res.err = (state == LX_RPAREN) ? ERR_PAREN : ERR_BRACE;
				else begin res.pop = 1'b1; st = 1'b1; end
			end
			LX_SEMI:   begin res.emit = 1'b1; res.kind = KIND_SEMI;   st = 1'b1; end
			LX_ASSIGN: begin res.emit = 1'b1; res.kind = KIND_ASSIGN; st = 1'b1; end
			LX_LANGLE: begin res.emit = 1'b1; res.kind = KIND_LANGLE; st = 1'b1; end
			LX_RANGLE: begin res.emit = 1'b1; res.kind = KIND_RANGLE; st = 1'b1; end
			LX_STAR:   begin res.emit = 1'b1; res.kind = KIND_STAR;   st = 1'b1; end
			LX_AMP:    begin res.emit = 1'b1; res.kind = KIND_AMP;    st = 1'b1; end
			LX_DCOLON: begin res.emit = 1'b1; res.kind = KIND_DCOLON; st = 1'b1; end
			LX_QUOTE: begin
				if (c == CH_QUOTE && !esc) begin
					res.emit = 1'b1; res.kind = KIND_STRING; res.nstate = LX_IGNORE;
				end else if (esc && (c == CH_QUOTE || c == CH_BSLASH) && len != '0) begin
					// escaped byte replaces the backslash
					res.wr = 1'b1; res.waddr = len - 1'b1; res.nesc = 1'b0;
				end else begin
					ap = 1'b1;
					res.nesc = tok_full ? esc : (c == CH_BSLASH);
				end
			end
			LX_COLON: begin
				if (c == ":") begin res.nstate = LX_DCOLON; ap = 1'b1; end
				else begin res.emit = 1'b1; res.kind = KIND_COLON; st = 1'b1; end
			end
			LX_SLASH: begin
				if (c == "/") res.nstate = LX_LINECOM;
				else if (c == "*") res.nstate = LX_BLOCKCOM;
				else begin res.emit = 1'b1; res.kind = KIND_SLASH; st = 1'b1; end
			end
			LX_LINECOM: if (c == CH_NL) st = 1'b1;
			LX_BLOCKCOM: if (c == "*") res.nstate = LX_BLOCKSTAR;
			LX_BLOCKSTAR: begin
				if (c == "/") begin
					res.nstate = LX_SPACE; res.nesc = 1'b0; res.nlen = TLEN_W'(1);
				end else if (c != "*") res.nstate = LX_BLOCKCOM;
			end
			default: st = 1'b1;
		endcase
		if (res.emit) res.nlen = '0;
		if (ap) begin
			if (tok_full) res.err = ERR_TOKEN;
			else begin
				res.wr = 1'b1; res.waddr = len; res.nlen = len + 1'b1; res.match = app_match;
			end
		end
		if (st) begin
			res.nstate = char_class(c);
			res.nesc = 1'b0;
			if (res.nstate != LX_QUOTE) begin
				res.nlen = TLEN_W'(1); res.wr = 1'b1; res.waddr = '0; res.match = start_match;
			end else res.nlen = '0;
		end
	end

endmodule

`default_nettype wire

>>> src/header_token_lexer_core.sv
// Header token lexer: one source byte in, token text bytes out as runs.
// Takes one byte per transfer and works on it alone: it accepts the byte,
// reads the top of the nesting stack memory and lexes it, then reads each
// token byte back from the token buffer memory (S_EMRD, S_EMWR), settles
// the run and, when a run is open, an error is pending or the stream ends,
// closes it; the last byte of a stream gets a second read, lex and settle
// pass for the flush. The receiver can hold off the read-back and the close.
// Results leave through an output register plus one holding stage, so
// run_last can be marked.
// Depends on htl_pkg, htl_lex_step and header_token_lexer_core_defines.svh.
`default_nettype none
`include "header_token_lexer_core_defines.svh"

module header_token_lexer_core #(
	parameter int MAX_TOKEN_LEN = 32,
	parameter int NEST_DEPTH    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  htl_pkg::htl_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output htl_pkg::htl_out_t out_data
);
	import htl_pkg::*;

	localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
	localparam int TIDX_W = $clog2(MAX_TOKEN_LEN);
	localparam int CNT_W  = $clog2(NEST_DEPTH + 1);
	localparam int IDX_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_LEX, S_EMRD, S_EMWR, S_POST, S_CLOSE
	} fsm_t;

	fsm_t             state_q;
	lx_state_t        lex_q;
	logic [LEN_W-1:0] len_q, emit_len_q, i_q;
	logic [CNT_W-1:0] count_q, cnt_m1;
	logic             esc_q, ehold_q, last_q, pass_q, pend_q, hold_v_q, done_q;
	logic [2:0]       held_q, err_q, code_q;
	logic [KW_N-1:0]  match_q;
	logic [7:0]       c_q;
	logic [4:0]       kind_q;
	htl_out_t         hold_q;

	logic [7:0] txt_mem [MAX_TOKEN_LEN];
	logic [7:0] txt_rd_q;
	logic       nest_mem [NEST_DEPTH];
	logic       nest_rd_q;

	lex_res_t         res;
	logic             out_free, can_push, last_byte, txt_we;
	logic [TIDX_W-1:0] txt_waddr;
	logic [LEN_W-1:0] i_nxt;
	htl_out_t         item;
	logic             out_load;
	htl_out_t         out_next;

	assign cnt_m1    = count_q - 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign can_push  = !hold_v_q || out_free;
	assign i_nxt     = i_q + 1'b1;
	assign last_byte = (i_nxt >= emit_len_q);
	assign in_ready  = (state_q == S_IDLE);

	htl_lex_step u_step (
		.state      (lex_q),
		.c          (c_q),
		.esc        (esc_q),
		.len        (TLEN_W'(len_q)),
		.match      (match_q),
		.tok_full   (len_q >= LEN_W'(MAX_TOKEN_LEN - 1)),
		.nest_empty (count_q == '0),
		.nest_full  (count_q >= CNT_W'(NEST_DEPTH)),
		.nest_top   (nest_rd_q),
		.res        (res)
	);

	// buffer writes from lexing; the start byte waits until the old token is read out
	assign txt_we = (state_q == S_LEX && res.wr && !res.emit) ||
		(state_q == S_EMWR && can_push && last_byte && pend_q);
	assign txt_waddr = (state_q == S_LEX) ? res.waddr[TIDX_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (txt_we) txt_mem[txt_waddr] <= c_q;
		txt_rd_q <= txt_mem[i_q[TIDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LEX && res.push) nest_mem[count_q[IDX_W-1:0]] <= res.push_bit;
		nest_rd_q <= nest_mem[cnt_m1[IDX_W-1:0]];
	end

	always_comb begin
		item             = '0;
		item.token_valid = 1'b1;
		item.token_kind  = kind_q;
		item.byte_valid  = (emit_len_q != '0);
		item.text_byte   = (emit_len_q != '0) ? txt_rd_q : 8'h00;
	end

	// output register load: a held item moves on, or the run is closed
	always_comb begin
		out_load = 1'b0;
		out_next = hold_q;
		if (state_q == S_EMWR && can_push && hold_v_q) out_load = 1'b1;
		if (state_q == S_CLOSE && out_free) begin
			out_load             = 1'b1;
			out_next             = hold_v_q ? hold_q : '0;
			out_next.run_last    = 1'b1;
			out_next.stream_done = done_q;
			out_next.error_code  = code_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_data  <= '0;
		end else if (out_load) begin
			out_valid <= 1'b1;
			out_data  <= out_next;
		end else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lex_q      <= LX_SPACE;
			len_q      <= '0;
			count_q    <= '0;
			esc_q      <= 1'b0;
			ehold_q    <= 1'b0;
			held_q     <= ERR_NONE;
			hold_v_q   <= 1'b0;
			last_q     <= 1'b0;
			pass_q     <= 1'b0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			err_q      <= ERR_NONE;
			code_q     <= ERR_NONE;
			c_q        <= '0;
			emit_len_q <= '0;
			i_q        <= '0;
			match_q    <= '0;
			kind_q     <= '0;
			hold_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					c_q    <= in_data.char_byte;
					last_q <= in_data.last_char;
					pass_q <= 1'b0;
					err_q  <= ERR_NONE;
					if (!ehold_q) state_q <= S_RD;
					else if (in_data.last_char) begin
						code_q  <= held_q;
						done_q  <= 1'b1;
						state_q <= S_CLOSE;
					end
				end
				S_RD: state_q <= S_LEX;
				S_LEX: begin
					lex_q      <= res.nstate;
					len_q      <= LEN_W'(res.nlen);
					esc_q      <= res.nesc;
					match_q    <= res.match;
					err_q      <= res.err;
					emit_len_q <= len_q;
					kind_q     <= res.kind;
					i_q        <= '0;
					pend_q     <= res.emit && res.wr;
					if (res.push) count_q <= count_q + 1'b1;
					else if (res.pop) count_q <= cnt_m1;
					state_q <= res.emit ? S_EMRD : S_POST;
				end
				S_EMRD: state_q <= S_EMWR;
				S_EMWR: if (can_push) begin
					hold_q   <= item;
					hold_v_q <= 1'b1;
					i_q      <= i_nxt;
					state_q  <= last_byte ? S_POST : S_EMRD;
				end
				S_POST: begin
					if (err_q != ERR_NONE) begin
						code_q  <= err_q;
						done_q  <= last_q;
						state_q <= S_CLOSE;
					end else if (last_q && !pass_q) begin
						c_q     <= CH_SPACE;
						pass_q  <= 1'b1;
						state_q <= S_RD;
					end else if (last_q) begin
						code_q  <= (lex_q != LX_SPACE || count_q != '0) ? ERR_UNCLOSED : ERR_NONE;
						done_q  <= 1'b1;
						state_q <= S_CLOSE;
					end else if (hold_v_q) begin
						code_q  <= ERR_NONE;
						done_q  <= 1'b0;
						state_q <= S_CLOSE;
					end else state_q <= S_IDLE;
				end
				S_CLOSE: if (out_free) begin
					hold_v_q <= 1'b0;
					if (done_q) begin
						lex_q   <= LX_SPACE;
						len_q   <= '0;
						count_q <= '0;
						esc_q   <= 1'b0;
						ehold_q <= 1'b0;
						held_q  <= ERR_NONE;
					end else if (code_q != ERR_NONE) begin
						ehold_q <= 1'b1;
						held_q  <= code_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HTL_ASSERT_NOW(a_idle_no_hold, state_q == S_IDLE, !hold_v_q, "item left in holding stage")
	`HTL_ASSERT_NOW(a_nest_bound, 1'b1, count_q <= CNT_W'(NEST_DEPTH), "nesting count overrun")
	`HTL_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_W'(MAX_TOKEN_LEN - 1), "token length overrun")
	`HTL_ASSERT_NEXT(a_done_rearm, state_q == S_CLOSE && out_free && done_q, count_q == '0 && !ehold_q && lex_q == LX_SPACE, "no rearm after stream end")

endmodule

`default_nettype wire
